// ===== rtl/core/npcs_pkg.sv =====
// ----------------------------------------------------------------------------
// npcs_pkg
// Types, constants and small helpers shared by the nearest palette color
// search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int CH_W        = 8;
  localparam int COLOR_W     = 3 * CH_W;
  localparam int DIST_W      = 18;
  localparam int NUM_W       = 2 * CH_W;
  localparam int RECIP_SHIFT = NUM_W + CH_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [DIST_W-1:0] DIST_INIT  = '1;
  localparam logic [CH_W-1:0]   FULL_SCALE = 8'd255;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_LAST  = 2'd2;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_DIRECT = 2'd1,
    ACT_MIX    = 2'd2,
    ACT_GRID   = 2'd3
  } npcs_action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_FIRST,
    ST_READ_SECOND,
    ST_CAPTURE,
    ST_PREP,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_POST,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } npcs_state_t;

  typedef struct packed {
    logic       accept;
    logic       rd_first;
    logic       rd_second;
    logic       cap_first;
    logic       cap_second;
    logic       prep;
    logic       div_start;
    logic       post;
    logic       scan_start;
    logic       scan_issue;
    logic       load_result;
    logic [1:0] chan;
  } npcs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic pipe_busy;
  } npcs_status_t;

  function automatic logic [CH_W-1:0] chan_of(input logic [COLOR_W-1:0] word,
                                              input logic [1:0] ch);
    logic [CH_W-1:0] res;
    case (ch)
      CHAN_RED:   res = word[23:16];
      CHAN_GREEN: res = word[15:8];
      default:    res = word[7:0];
    endcase
    return res;
  endfunction

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/core/npcs_query_if.sv =====
// ----------------------------------------------------------------------------
// npcs_query_if
// Input channel: one item is a palette write or a search query.
// ----------------------------------------------------------------------------
interface npcs_query_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] first_index;
  logic [7:0] second_index;
  logic [7:0] mix_level;
  logic [7:0] red_value;
  logic [7:0] green_value;
  logic [7:0] blue_value;

  modport source (
    output valid, action, first_index, second_index, mix_level,
           red_value, green_value, blue_value,
    input  ready
  );

  modport sink (
    input  valid, action, first_index, second_index, mix_level,
           red_value, green_value, blue_value,
    output ready
  );
endinterface

// ===== rtl/core/npcs_result_if.sv =====
// ----------------------------------------------------------------------------
// npcs_result_if
// Output channel: one item is the index of the nearest palette entry.
// ----------------------------------------------------------------------------
interface npcs_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (
    output valid, color_index,
    input  ready
  );

  modport sink (
    input  valid, color_index,
    output ready
  );
endinterface

// ===== rtl/core/nearest_palette_color_search_top.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top: a write leaves the input ready; a direct
// query goes to the palette scan, a grid query first forms its target per
// channel with the divider, and a mix query reads two palette entries before that.
// The scan takes one entry per cycle. Input is held off until the result is
// loaded (waiting on output stalls); the next item can enter in the next cycle.
// Synchronous reset clears the controller and output valid; palette is unset.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top import npcs_pkg::*; #(
  parameter int PALETTE_SIZE = 256,
  parameter int MIX_LEVELS   = 16,
  parameter int GRID_RES     = 32
) (
  input logic         clk,
  input logic         rst,
  npcs_query_if.sink  query,
  npcs_result_if.source result
);

  npcs_cmd_t    cmd;
  npcs_status_t status;

  npcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .action    (query.action),
    .in_ready  (query.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  npcs_datapath #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .MIX_LEVELS   (MIX_LEVELS),
    .GRID_RES     (GRID_RES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .action       (query.action),
    .first_index  (query.first_index),
    .second_index (query.second_index),
    .mix_level    (query.mix_level),
    .red_value    (query.red_value),
    .green_value  (query.green_value),
    .blue_value   (query.blue_value),
    .color_index  (result.color_index)
  );

endmodule

// ===== rtl/core/npcs_divider.sv =====
// ----------------------------------------------------------------------------
// npcs_divider
// Division of a 16-bit numerator by a constant denominator, done as a
// multiplication by the scaled reciprocal; the quotient is registered in the
// cycle after start.
// ----------------------------------------------------------------------------
module npcs_divider import npcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   numer,
  input  logic [RECIP_W-1:0] recip,
  output logic [NUM_W-1:0]   quotient,
  output logic               done
);

  logic [NUM_W+RECIP_W-1:0] product;

  assign product = (NUM_W + RECIP_W)'(numer) * (NUM_W + RECIP_W)'(recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= product[RECIP_SHIFT +: NUM_W];
    end
  end

endmodule

// ===== rtl/core/npcs_datapath.sv =====
// ----------------------------------------------------------------------------
// npcs_datapath
// Palette memory, target color forming for mix and grid queries, and the
// pipelined distance scan that keeps the nearest entry.
// ----------------------------------------------------------------------------
module npcs_datapath import npcs_pkg::*; #(
  parameter int PALETTE_SIZE = 256,
  parameter int MIX_LEVELS   = 16,
  parameter int GRID_RES     = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  npcs_cmd_t    cmd,
  output npcs_status_t status,
  input  logic [1:0]   action,
  input  logic [7:0]   first_index,
  input  logic [7:0]   second_index,
  input  logic [7:0]   mix_level,
  input  logic [7:0]   red_value,
  input  logic [7:0]   green_value,
  input  logic [7:0]   blue_value,
  output logic [7:0]   color_index
);

  localparam int ADDR_W = $clog2(PALETTE_SIZE);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_SIZE - 1);
  localparam logic [CH_W:0]   PAL_LIMIT  = (CH_W + 1)'(PALETTE_SIZE);
  localparam logic [CH_W:0]   MIX_LIMIT  = (CH_W + 1)'(MIX_LEVELS);
  localparam logic [CH_W:0]   GRID_LIMIT = (CH_W + 1)'(GRID_RES);
  localparam logic [CH_W-1:0] MIX_DEN    = CH_W'(MIX_LEVELS - 1);
  localparam logic [CH_W-1:0] GRID_DEN   = CH_W'(GRID_RES - 1);
  localparam logic [RECIP_W-1:0] MIX_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + MIX_LEVELS - 2) / (MIX_LEVELS - 1));
  localparam logic [RECIP_W-1:0] GRID_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + GRID_RES - 2) / (GRID_RES - 1));

  logic [COLOR_W-1:0] palette_store [PALETTE_SIZE];
  logic [COLOR_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic               we;

  logic [1:0]         act_q;
  logic [7:0]         idx1_q;
  logic [7:0]         idx2_q;
  logic [7:0]         level_q;
  logic [CH_W-1:0]    tgt [3];
  logic [COLOR_W-1:0] color1;
  logic [COLOR_W-1:0] color2;
  logic [ADDR_W-1:0]  idx1_addr;
  logic [ADDR_W-1:0]  idx2_addr;

  logic               is_mix;
  logic [CH_W-1:0]    c1;
  logic [CH_W-1:0]    c2;
  logic [CH_W-1:0]    lvl_sat;
  logic [CH_W-1:0]    coord;
  logic [CH_W-1:0]    coord_sat;
  logic [CH_W-1:0]    den;
  logic [RECIP_W-1:0] recip;
  logic               neg;
  logic [NUM_W-1:0]   prod;
  logic [NUM_W-1:0]   numer;
  logic [NUM_W-1:0]   quotient;
  logic [CH_W-1:0]    q8;
  logic [CH_W-1:0]    chan_result;
  logic               div_done;

  logic [ADDR_W-1:0]  scan_addr;
  logic               s1_valid;
  logic               s2_valid;
  logic [ADDR_W-1:0]  s1_idx;
  logic [ADDR_W-1:0]  s2_idx;
  logic [NUM_W-1:0]   sq_r;
  logic [NUM_W-1:0]   sq_g;
  logic [NUM_W-1:0]   sq_b;
  logic [CH_W-1:0]    d_r;
  logic [CH_W-1:0]    d_g;
  logic [CH_W-1:0]    d_b;
  logic [DIST_W-1:0]  cand_dist;
  logic [DIST_W-1:0]  best_distance;
  logic [ADDR_W-1:0]  best_entry;

  assign we = cmd.accept && (action == ACT_WRITE) && ({1'b0, first_index} < PAL_LIMIT);

  always_comb begin
    if (cmd.rd_first) begin
      raddr = idx1_addr;
    end else if (cmd.rd_second) begin
      raddr = idx2_addr;
    end else begin
      raddr = scan_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      palette_store[first_index[ADDR_W-1:0]] <= {red_value, green_value, blue_value};
    end
    rdata <= palette_store[raddr];
  end

  assign idx1_addr = ({1'b0, idx1_q} >= PAL_LIMIT) ? LAST_ADDR : idx1_q[ADDR_W-1:0];
  assign idx2_addr = ({1'b0, idx2_q} >= PAL_LIMIT) ? LAST_ADDR : idx2_q[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q   <= action;
      idx1_q  <= first_index;
      idx2_q  <= second_index;
      level_q <= mix_level;
      tgt[0]  <= red_value;
      tgt[1]  <= green_value;
      tgt[2]  <= blue_value;
    end else if (cmd.post) begin
      tgt[cmd.chan] <= chan_result;
    end
    if (cmd.cap_first) begin
      color1 <= rdata;
    end
    if (cmd.cap_second) begin
      color2 <= rdata;
    end
  end

  // Each channel of a mix or grid target is formed as a product, then an
  // exact division by the level or grid step count.
  assign is_mix    = (act_q == ACT_MIX);
  assign c1        = chan_of(color1, cmd.chan);
  assign c2        = chan_of(color2, cmd.chan);
  assign lvl_sat   = ({1'b0, level_q} >= MIX_LIMIT) ? MIX_DEN : level_q;
  assign coord     = tgt[cmd.chan];
  assign coord_sat = ({1'b0, coord} >= GRID_LIMIT) ? GRID_DEN : coord;
  assign den       = is_mix ? MIX_DEN : GRID_DEN;
  assign recip     = is_mix ? MIX_RECIP : GRID_RECIP;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (is_mix) begin
        neg  <= (c1 > c2);
        prod <= NUM_W'(lvl_sat) * NUM_W'(abs_diff(c1, c2));
      end else begin
        neg  <= 1'b0;
        prod <= NUM_W'(coord_sat) * NUM_W'(FULL_SCALE);
      end
    end
  end

  // A falling blend rounds the step up so that the channel rounds down.
  assign numer = prod + (neg ? (NUM_W'(den) - 1'b1) : '0);
  assign q8    = quotient[CH_W-1:0];

  always_comb begin
    if (!is_mix) begin
      chan_result = q8;
    end else if (neg) begin
      chan_result = c1 - q8;
    end else begin
      chan_result = c1 + q8;
    end
  end

  npcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .numer    (numer),
    .recip    (recip),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_issue) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  assign d_r = abs_diff(tgt[0], rdata[23:16]);
  assign d_g = abs_diff(tgt[1], rdata[15:8]);
  assign d_b = abs_diff(tgt[2], rdata[7:0]);

  always_ff @(posedge clk) begin
    s1_idx <= scan_addr;
    s2_idx <= s1_idx;
    sq_r   <= NUM_W'(d_r) * NUM_W'(d_r);
    sq_g   <= NUM_W'(d_g) * NUM_W'(d_g);
    sq_b   <= NUM_W'(d_b) * NUM_W'(d_b);
  end

  assign cand_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  // Strict less-than keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      best_distance <= DIST_INIT;
      best_entry    <= '0;
    end else if (s2_valid && (cand_dist < best_distance)) begin
      best_distance <= cand_dist;
      best_entry    <= s2_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      color_index <= 8'(best_entry);
    end
  end

  assign status.div_done  = div_done;
  assign status.scan_last = (scan_addr == LAST_ADDR);
  assign status.pipe_busy = s1_valid || s2_valid;

endmodule

// ===== rtl/core/npcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// npcs_ctrl
// Sequencer for writes and queries: target forming, scan, and the output
// register handshake.
// ----------------------------------------------------------------------------
module npcs_ctrl import npcs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   action,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output npcs_cmd_t    cmd,
  input  npcs_status_t status
);

  npcs_state_t state;
  npcs_state_t state_next;
  logic [1:0]  chan;
  logic        accept;
  logic        can_load;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_ready && in_valid;
  assign can_load = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_WRITE:  state_next = ST_IDLE;
            ACT_DIRECT: state_next = ST_SCAN_INIT;
            ACT_MIX:    state_next = ST_READ_FIRST;
            default:    state_next = ST_PREP;
          endcase
        end
      end
      ST_READ_FIRST:  state_next = ST_READ_SECOND;
      ST_READ_SECOND: state_next = ST_CAPTURE;
      ST_CAPTURE:     state_next = ST_PREP;
      ST_PREP:        state_next = ST_DIV_LOAD;
      ST_DIV_LOAD:    state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_POST;
        end
      end
      ST_POST: begin
        state_next = (chan == CHAN_LAST) ? ST_SCAN_INIT : ST_PREP;
      end
      ST_SCAN_INIT:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.chan = chan;
    case (state)
      ST_IDLE:        cmd.accept      = accept;
      ST_READ_FIRST:  cmd.rd_first    = 1'b1;
      ST_READ_SECOND: begin
        cmd.rd_second = 1'b1;
        cmd.cap_first = 1'b1;
      end
      ST_CAPTURE:     cmd.cap_second  = 1'b1;
      ST_PREP:        cmd.prep        = 1'b1;
      ST_DIV_LOAD:    cmd.div_start   = 1'b1;
      ST_POST:        cmd.post        = 1'b1;
      ST_SCAN_INIT:   cmd.scan_start  = 1'b1;
      ST_SCAN:        cmd.scan_issue  = 1'b1;
      ST_FINISH:      cmd.load_result = can_load;
      default:        cmd.chan        = chan;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chan      <= CHAN_RED;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        chan <= CHAN_RED;
      end else if (cmd.post) begin
        chan <= chan + 1'b1;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/npcs_checker.sv =====
// ----------------------------------------------------------------------------
// npcs_checker
// Port-level checks of the nearest palette color search block.
// ----------------------------------------------------------------------------
module npcs_checker import npcs_pkg::*; #(
  parameter int PALETTE_SIZE = 256
) (
  input logic       clk,
  input logic       rst,
  input logic       q_valid,
  input logic       q_ready,
  input logic [1:0] q_action,
  input logic       r_valid,
  input logic       r_ready,
  input logic [7:0] r_index
);

  logic [1:0] pending;
  logic       q_fire;
  logic       r_fire;
  logic       query_fire;
  logic       write_fire;

  assign q_fire     = q_valid && q_ready;
  assign r_fire     = r_valid && r_ready;
  assign write_fire = q_fire && (q_action == ACT_WRITE);
  assign query_fire = q_fire && (q_action != ACT_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, query_fire} - {1'b0, r_fire};
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_index))
    else $error("Result item changed before it was taken.");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_fire |=> !q_ready)
    else $error("Query accepted while another was still in work.");

  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    write_fire |=> q_ready)
    else $error("Palette write stalled the input.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (r_fire |-> pending != 2'd0) and (pending != 2'd3))
    else $error("Result item count does not match accepted queries.");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> ({1'b0, r_index} < 9'(PALETTE_SIZE)))
    else $error("Result index beyond the palette.");

endmodule

bind nearest_palette_color_search_top npcs_checker #(
  .PALETTE_SIZE (PALETTE_SIZE)
) u_npcs_checker (
  .clk      (clk),
  .rst      (rst),
  .q_valid  (query.valid),
  .q_ready  (query.ready),
  .q_action (query.action),
  .r_valid  (result.valid),
  .r_ready  (result.ready),
  .r_index  (result.color_index)
);

// ===== tb/nearest_palette_color_search_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top_test
// Fills the whole palette, then runs directed and random palette writes and
// direct, mix and grid queries with random sender gaps and receiver stalls.
// Each returned index is checked against a local palette copy and search.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top_test;
  import npcs_pkg::*;

  localparam int PALETTE_SIZE = 256;
  localparam int MIX_LEVELS   = 16;
  localparam int GRID_RES     = 32;
  localparam int RANDOM_ITEMS = 1620;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    npcs_action_t action;
    logic [7:0]   first_index;
    logic [7:0]   second_index;
    logic [7:0]   mix_level;
    logic [7:0]   red_value;
    logic [7:0]   green_value;
    logic [7:0]   blue_value;
  } query_item_t;

  logic clk;
  logic rst;

  npcs_query_if  query_ch ();
  npcs_result_if result_ch ();

  nearest_palette_color_search_top #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .MIX_LEVELS   (MIX_LEVELS),
    .GRID_RES     (GRID_RES)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  logic [23:0] palette_shadow [PALETTE_SIZE];
  logic [7:0]  expected_indices [$];
  int unsigned mismatch_count = 0;
  int          burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("[nearest_palette_color_search_top] ERROR");
    $finish;
  end

  function automatic logic [7:0] blend_channel(input logic [7:0] c1, input logic [7:0] c2,
                                               input logic [7:0] level);
    int den;
    int num;
    den = MIX_LEVELS - 1;
    if (c2 >= c1) begin
      num = int'(level) * (int'(c2) - int'(c1));
      return 8'(int'(c1) + num / den);
    end
    num = int'(level) * (int'(c1) - int'(c2));
    return 8'(int'(c1) - (num + den - 1) / den);
  endfunction

  function automatic logic [7:0] grid_to_channel(input logic [7:0] coord);
    int c;
    c = (coord >= GRID_RES) ? GRID_RES - 1 : int'(coord);
    return 8'((c * int'(FULL_SCALE)) / (GRID_RES - 1));
  endfunction

  function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    int best_dist;
    int cand_dist;
    int dr;
    int dg;
    int db;
    logic [7:0] best_idx;
    best_dist = int'(DIST_INIT);
    best_idx = '0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      dr = int'(r) - int'(palette_shadow[i][23:16]);
      dg = int'(g) - int'(palette_shadow[i][15:8]);
      db = int'(b) - int'(palette_shadow[i][7:0]);
      cand_dist = dr * dr + dg * dg + db * db;
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best_idx = 8'(i);
        if (cand_dist == 0) break;
      end
    end
    return best_idx;
  endfunction

  function automatic void predict_item(input query_item_t item);
    logic [23:0] w1;
    logic [23:0] w2;
    logic [7:0]  lvl;
    case (item.action)
      ACT_WRITE: begin
        if (item.first_index < PALETTE_SIZE)
          palette_shadow[item.first_index] = {item.red_value, item.green_value,
                                              item.blue_value};
      end
      ACT_DIRECT: begin
        expected_indices.push_back(nearest_entry(item.red_value, item.green_value,
                                                 item.blue_value));
      end
      ACT_MIX: begin
        w1 = palette_shadow[(item.first_index >= PALETTE_SIZE) ? PALETTE_SIZE - 1
                                                                : item.first_index];
        w2 = palette_shadow[(item.second_index >= PALETTE_SIZE) ? PALETTE_SIZE - 1
                                                                 : item.second_index];
        lvl = (item.mix_level >= MIX_LEVELS) ? 8'(MIX_LEVELS - 1) : item.mix_level;
        expected_indices.push_back(nearest_entry(blend_channel(w1[23:16], w2[23:16], lvl),
                                                 blend_channel(w1[15:8], w2[15:8], lvl),
                                                 blend_channel(w1[7:0], w2[7:0], lvl)));
      end
      default: begin
        expected_indices.push_back(nearest_entry(grid_to_channel(item.red_value),
                                                 grid_to_channel(item.green_value),
                                                 grid_to_channel(item.blue_value)));
      end
    endcase
  endfunction

  function automatic query_item_t random_item(input npcs_action_t action);
    query_item_t item;
    item.action       = action;
    item.first_index  = 8'($urandom);
    item.second_index = 8'($urandom);
    item.mix_level    = 8'($urandom);
    item.red_value    = 8'($urandom);
    item.green_value  = 8'($urandom);
    item.blue_value   = 8'($urandom);
    return item;
  endfunction

  task automatic send_item(input query_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        query_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    @(negedge clk);
    query_ch.valid        = 1'b1;
    query_ch.action       = item.action;
    query_ch.first_index  = item.first_index;
    query_ch.second_index = item.second_index;
    query_ch.mix_level    = item.mix_level;
    query_ch.red_value    = item.red_value;
    query_ch.green_value  = item.green_value;
    query_ch.blue_value   = item.blue_value;
    do @(posedge clk); while (!(query_ch.valid && query_ch.ready));
    burst_left--;
    predict_item(item);
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic [23:0] color);
    query_item_t item;
    item = random_item(ACT_WRITE);
    item.first_index = idx;
    {item.red_value, item.green_value, item.blue_value} = color;
    send_item(item);
  endtask

  task automatic direct_query(input logic [23:0] color);
    query_item_t item;
    item = random_item(ACT_DIRECT);
    {item.red_value, item.green_value, item.blue_value} = color;
    send_item(item);
  endtask

  task automatic mix_query(input logic [7:0] idx1, input logic [7:0] idx2,
                           input logic [7:0] level);
    query_item_t item;
    item = random_item(ACT_MIX);
    item.first_index  = idx1;
    item.second_index = idx2;
    item.mix_level    = level;
    send_item(item);
  endtask

  task automatic grid_query(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    query_item_t item;
    item = random_item(ACT_GRID);
    item.red_value   = r;
    item.green_value = g;
    item.blue_value  = b;
    send_item(item);
  endtask

  task automatic fill_palette();
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      if (i == 0) write_entry(8'(i), 24'h000000);
      else if (i == PALETTE_SIZE - 1) write_entry(8'(i), 24'hFFFFFF);
      else if (i == 180) write_entry(8'(i), palette_shadow[37]);
      else write_entry(8'(i), 24'($urandom));
    end
  endtask

  task automatic test_direct_extremes();
    direct_query(24'h000000);
    direct_query(24'hFFFFFF);
    direct_query(24'hFF00FF);
    direct_query(24'h00FF00);
  endtask

  task automatic test_exact_match();
    direct_query(palette_shadow[128]);
    direct_query(palette_shadow[254]);
    direct_query(palette_shadow[180]);
  endtask

  task automatic test_ties();
    write_entry(8'd5, 24'h3C5A78);
    write_entry(8'd9, 24'h3C5A78);
    direct_query(24'h3C5A78);
    write_entry(8'd3, 24'h646464);
    write_entry(8'd4, 24'h6E6464);
    direct_query(24'h696464);
  endtask

  task automatic test_mix_queries();
    mix_query(8'd0, 8'd255, 8'd0);
    mix_query(8'd0, 8'd255, 8'(MIX_LEVELS - 1));
    mix_query(8'd255, 8'd0, 8'd7);
    mix_query(8'd37, 8'd200, 8'(MIX_LEVELS));
    mix_query(8'd200, 8'd37, 8'd255);
    mix_query(8'd64, 8'd64, 8'd9);
  endtask

  task automatic test_grid_queries();
    grid_query(8'd0, 8'd0, 8'd0);
    grid_query(8'(GRID_RES - 1), 8'(GRID_RES - 1), 8'(GRID_RES - 1));
    grid_query(8'(GRID_RES), 8'd255, 8'd128);
    grid_query(8'd1, 8'd16, 8'(GRID_RES - 2));
  endtask

  task automatic test_random_traffic();
    query_item_t item;
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        item = random_item(ACT_WRITE);
        if ($urandom_range(0, 7) == 0)
          {item.red_value, item.green_value, item.blue_value} =
            palette_shadow[$urandom_range(0, PALETTE_SIZE - 1)];
      end else if (pick < 55) begin
        item = random_item(ACT_DIRECT);
        if ($urandom_range(0, 4) == 0)
          {item.red_value, item.green_value, item.blue_value} =
            palette_shadow[$urandom_range(0, PALETTE_SIZE - 1)];
      end else if (pick < 78) begin
        item = random_item(ACT_MIX);
        if ($urandom_range(0, 3) != 0) item.mix_level = 8'($urandom_range(0, MIX_LEVELS - 1));
      end else begin
        item = random_item(ACT_GRID);
        if ($urandom_range(0, 4) != 0) item.red_value = 8'($urandom_range(0, GRID_RES - 1));
        if ($urandom_range(0, 4) != 0) item.green_value = 8'($urandom_range(0, GRID_RES - 1));
        if ($urandom_range(0, 4) != 0) item.blue_value = 8'($urandom_range(0, GRID_RES - 1));
      end
      send_item(item);
    end
  endtask

  initial begin
    logic [7:0] stall_pattern;
    int unsigned stall_cycle;
    stall_pattern = 8'hFF;
    stall_cycle = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cycle % 200 == 0) begin
        if ($urandom_range(0, 3) == 0) stall_pattern = 8'hFF;
        else stall_pattern = 8'($urandom) | 8'h01;
      end
      result_ch.ready = stall_pattern[stall_cycle % 8];
      stall_cycle++;
    end
  end

  always @(posedge clk) begin : check_results
    logic [7:0] want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_indices.size() == 0) begin
        $error("color_index: expected none, got %0d", result_ch.color_index);
        mismatch_count++;
      end else begin
        want = expected_indices.pop_front();
        if (result_ch.color_index !== want) begin
          $error("color_index: expected %0d, got %0d", want, result_ch.color_index);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    query_ch.valid        = 1'b0;
    query_ch.action       = ACT_WRITE;
    query_ch.first_index  = '0;
    query_ch.second_index = '0;
    query_ch.mix_level    = '0;
    query_ch.red_value    = '0;
    query_ch.green_value  = '0;
    query_ch.blue_value   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    fill_palette();
    test_direct_extremes();
    test_exact_match();
    test_ties();
    test_mix_queries();
    test_grid_queries();
    test_random_traffic();

    @(negedge clk);
    query_ch.valid = 1'b0;
    while (expected_indices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_indices.size() == 0) begin
      $display("[nearest_palette_color_search_top] OK");
    end else begin
      $display("[nearest_palette_color_search_top] ERROR");
    end
    $finish;
  end

endmodule
